@@ hdl/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

@@ hdl/orsat_pkg.sv @@
package orsat_pkg;

  // two shapes per beat, four corners each, four candidate axes
  localparam int unsigned NumRects   = 2;
  localparam int unsigned NumPoints  = 3;
  localparam int unsigned NumCorners = 4;
  localparam int unsigned NumAxes    = 4;
  localparam int unsigned EdgesPerRect = 2;

  // given points of one shape
  localparam int unsigned PtTl = 0;
  localparam int unsigned PtTr = 1;
  localparam int unsigned PtBl = 2;

  // corner order around the parallelogram
  localparam int unsigned CornerTl = 0;
  localparam int unsigned CornerTr = 1;
  localparam int unsigned CornerBr = 2;
  localparam int unsigned CornerBl = 3;

  // rectangle slots
  localparam int unsigned RectA = 0;
  localparam int unsigned RectB = 1;

endpackage

@@ hdl/orsat_axis.sv @@
module orsat_axis #(
  parameter int unsigned CornerWidth = 18
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [CornerWidth-1:0] cx_i [orsat_pkg::NumRects][orsat_pkg::NumCorners],
  input  logic signed [CornerWidth-1:0] cy_i [orsat_pkg::NumRects][orsat_pkg::NumCorners],
  input  logic signed [CornerWidth-1:0] ax_i,
  input  logic signed [CornerWidth-1:0] ay_i,
  output logic                          meet_o
);
  import orsat_pkg::*;

  localparam int unsigned ProdWidth = 2 * CornerWidth;
  localparam int unsigned DotWidth  = ProdWidth + 1;

  logic signed [ProdWidth-1:0] prod_x_q [NumRects][NumCorners];
  logic signed [ProdWidth-1:0] prod_y_q [NumRects][NumCorners];
  logic signed [DotWidth-1:0]  dot_d    [NumRects][NumCorners];
  logic signed [DotWidth-1:0]  dot_q    [NumRects][NumCorners];
  logic signed [DotWidth-1:0]  lo_d     [NumRects];
  logic signed [DotWidth-1:0]  hi_d     [NumRects];
  logic signed [DotWidth-1:0]  lo_q     [NumRects];
  logic signed [DotWidth-1:0]  hi_q     [NumRects];

  // stage 3: one exact product per coordinate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < NumRects; r++) begin
        for (int c = 0; c < NumCorners; c++) begin
          prod_x_q[r][c] <= ProdWidth'(cx_i[r][c]) * ProdWidth'(ax_i);
          prod_y_q[r][c] <= ProdWidth'(cy_i[r][c]) * ProdWidth'(ay_i);
        end
      end
    end
  end

  // stage 4: projections (normal is (-ey, ex), passed as ax = -ey, ay = ex)
  always_comb begin
    for (int r = 0; r < NumRects; r++) begin
      for (int c = 0; c < NumCorners; c++) begin
        dot_d[r][c] = DotWidth'(prod_y_q[r][c]) + DotWidth'(prod_x_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= dot_d;
    end
  end

  // stage 5: interval of each shape via a two level min/max tree
  always_comb begin
    logic signed [DotWidth-1:0] lo01, lo23, hi01, hi23;
    for (int r = 0; r < NumRects; r++) begin
      lo01 = (dot_q[r][1] < dot_q[r][0]) ? dot_q[r][1] : dot_q[r][0];
      lo23 = (dot_q[r][3] < dot_q[r][2]) ? dot_q[r][3] : dot_q[r][2];
      hi01 = (dot_q[r][1] > dot_q[r][0]) ? dot_q[r][1] : dot_q[r][0];
      hi23 = (dot_q[r][3] > dot_q[r][2]) ? dot_q[r][3] : dot_q[r][2];
      lo_d[r] = (lo23 < lo01) ? lo23 : lo01;
      hi_d[r] = (hi23 > hi01) ? hi23 : hi01;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // closed intervals: touching counts as meeting
  assign meet_o = !((hi_q[RectA] < lo_q[RectB]) || (hi_q[RectB] < lo_q[RectA]));

endmodule

@@ hdl/oriented_rect_overlap_sat.sv @@
// an accepted input beat is registered at the input, corner, product, projection and
//   interval stages and then at the output register; throughput: one rectangle pair
//   per cycle while the output is not stalled, all stages advancing together
// a stalled output holds every stage; in_ready_o is high whenever the result slot frees
// reset clears the valid flags only; data registers are not reset
`include "assert_macros.svh"

module oriented_rect_overlap_sat #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] a_top_left_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_left_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_right_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_right_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_bottom_left_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_bottom_left_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_left_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_left_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_right_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_right_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_bottom_left_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_bottom_left_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          overlapping_o
);
  import orsat_pkg::*;

  // corners and axes carry two extra bits so the derived corner never wraps
  localparam int unsigned CornerWidth = COORD_WIDTH + 2;

  logic en;

  logic                          v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic                          pre3_q, pre4_q, pre5_q, pre_d;
  logic                          overlapping_q;
  logic signed [COORD_WIDTH-1:0] px_q [NumRects][NumPoints];
  logic signed [COORD_WIDTH-1:0] py_q [NumRects][NumPoints];
  logic signed [CornerWidth-1:0] cx_d [NumRects][NumCorners];
  logic signed [CornerWidth-1:0] cy_d [NumRects][NumCorners];
  logic signed [CornerWidth-1:0] cx_q [NumRects][NumCorners];
  logic signed [CornerWidth-1:0] cy_q [NumRects][NumCorners];
  logic signed [CornerWidth-1:0] ax_d [NumAxes];
  logic signed [CornerWidth-1:0] ay_d [NumAxes];
  logic signed [CornerWidth-1:0] ax_q [NumAxes];
  logic signed [CornerWidth-1:0] ay_q [NumAxes];
  logic        [NumAxes-1:0]     meet;

  // whole pipeline moves when the result slot is empty or being taken
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign overlapping_o = overlapping_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[RectA][PtTl] <= a_top_left_x_i;
      py_q[RectA][PtTl] <= a_top_left_y_i;
      px_q[RectA][PtTr] <= a_top_right_x_i;
      py_q[RectA][PtTr] <= a_top_right_y_i;
      px_q[RectA][PtBl] <= a_bottom_left_x_i;
      py_q[RectA][PtBl] <= a_bottom_left_y_i;
      px_q[RectB][PtTl] <= b_top_left_x_i;
      py_q[RectB][PtTl] <= b_top_left_y_i;
      px_q[RectB][PtTr] <= b_top_right_x_i;
      py_q[RectB][PtTr] <= b_top_right_y_i;
      px_q[RectB][PtBl] <= b_bottom_left_x_i;
      py_q[RectB][PtBl] <= b_bottom_left_y_i;
    end
  end

  // stage 2: derived corner and edge normals
  always_comb begin
    logic signed [CornerWidth-1:0] ex, ey;
    for (int r = 0; r < NumRects; r++) begin
      cx_d[r][CornerTl] = CornerWidth'(px_q[r][PtTl]);
      cy_d[r][CornerTl] = CornerWidth'(py_q[r][PtTl]);
      cx_d[r][CornerTr] = CornerWidth'(px_q[r][PtTr]);
      cy_d[r][CornerTr] = CornerWidth'(py_q[r][PtTr]);
      cx_d[r][CornerBl] = CornerWidth'(px_q[r][PtBl]);
      cy_d[r][CornerBl] = CornerWidth'(py_q[r][PtBl]);
      cx_d[r][CornerBr] = cx_d[r][CornerTr] + cx_d[r][CornerBl] - cx_d[r][CornerTl];
      cy_d[r][CornerBr] = cy_d[r][CornerTr] + cy_d[r][CornerBl] - cy_d[r][CornerTl];
      for (int e = 0; e < EdgesPerRect; e++) begin
        if (e == 0) begin
          ex = cx_d[r][CornerTr] - cx_d[r][CornerTl];
          ey = cy_d[r][CornerTr] - cy_d[r][CornerTl];
        end else begin
          ex = cx_d[r][CornerBl] - cx_d[r][CornerTl];
          ey = cy_d[r][CornerBl] - cy_d[r][CornerTl];
        end
        ax_d[r * EdgesPerRect + e] = -ey;
        ay_d[r * EdgesPerRect + e] = ex;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  // bounding extent prefilter on the true corner min and max
  always_comb begin
    logic signed [CornerWidth-1:0] xlo [NumRects];
    logic signed [CornerWidth-1:0] xhi [NumRects];
    logic signed [CornerWidth-1:0] ylo [NumRects];
    logic signed [CornerWidth-1:0] yhi [NumRects];
    for (int r = 0; r < NumRects; r++) begin
      xlo[r] = cx_q[r][0];
      xhi[r] = cx_q[r][0];
      ylo[r] = cy_q[r][0];
      yhi[r] = cy_q[r][0];
      for (int c = 1; c < NumCorners; c++) begin
        if (cx_q[r][c] < xlo[r]) xlo[r] = cx_q[r][c];
        if (cx_q[r][c] > xhi[r]) xhi[r] = cx_q[r][c];
        if (cy_q[r][c] < ylo[r]) ylo[r] = cy_q[r][c];
        if (cy_q[r][c] > yhi[r]) yhi[r] = cy_q[r][c];
      end
    end
    pre_d = !((xhi[RectA] < xlo[RectB]) || (xhi[RectB] < xlo[RectA])) &&
            !((yhi[RectA] < ylo[RectB]) || (yhi[RectB] < ylo[RectA]));
  end

  // prefilter result travels alongside the axis pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      pre3_q <= pre_d;
      pre4_q <= pre3_q;
      pre5_q <= pre4_q;
    end
  end

  // stages 3 to 5: one projection unit per edge normal
  for (genvar k = 0; k < NumAxes; k++) begin : g_axis
    orsat_axis #(
      .CornerWidth(CornerWidth)
    ) u_axis (
      .clk_i (clk_i),
      .en_i  (en),
      .cx_i  (cx_q),
      .cy_i  (cy_q),
      .ax_i  (ax_q[k]),
      .ay_i  (ay_q[k]),
      .meet_o(meet[k])
    );
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      overlapping_q <= pre5_q && (&meet);
    end
  end

  // a pair rejected by the prefilter never reports overlap
  `ASSERT_NEXT(a_prefilter_rejects, clk_i, rst_ni, en && v5_q && !pre5_q, !overlapping_q, "prefilter reject lost")
  // a bubble in the last stage never becomes a result beat
  `ASSERT_NEXT(a_bubble_no_beat, clk_i, rst_ni, en && !v5_q, !out_valid_q, "result beat from a bubble")
  // a stalled pipeline keeps its last stage
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !en, $stable(v5_q) && $stable(pre5_q), "pipeline moved while stalled")

endmodule
